// File: rtl/stlb_pkg.sv
package stlb_pkg;

	// default number of translation entries
	localparam int ENTRY_COUNT_DEF = 16;

	// address split for 4 KiB pages
	localparam int OFS_W = 12;
	localparam int VPN_W = 20;
	localparam int PFN_W = 20;
	localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;

	// request codes
	localparam logic [2:0] REQ_TRANSLATE = 3'd0;
	localparam logic [2:0] REQ_WRITE_RND = 3'd1;
	localparam logic [2:0] REQ_READ_ENT  = 3'd2;
	localparam logic [2:0] REQ_PROBE     = 3'd3;
	localparam logic [2:0] REQ_INVAL     = 3'd4;
	localparam logic [2:0] REQ_REG_RD    = 3'd5;
	localparam logic [2:0] REQ_REG_WR    = 3'd6;

	// register selects
	localparam logic [1:0] REG_ENTRY_HI = 2'd0;
	localparam logic [1:0] REG_ENTRY_LO = 2'd1;
	localparam logic [1:0] REG_INDEX    = 2'd2;
	localparam logic [1:0] REG_BAD_ADDR = 2'd3;

	// one translation entry
	typedef struct packed {
		logic [VPN_W-1:0] vpn;
		logic [PFN_W-1:0] pfn;
		logic             valid;
		logic             dirty;
		logic [2:0]       rwx;
		logic             user;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic match;
		logic exec;
	} cmd_t;

endpackage

// File: rtl/software_managed_tlb.sv
// software managed tlb, fully associative, 4 KiB pages
// a request is captured, its parallel tag compare is registered, and the execute step registers the result beat
// a new request is taken only after the previous one has passed capture, tag compare and execute
// the execute step waits while a previous result beat is still stalled at the output
// reset: asynchronous, clears all entries, software registers and control state, random slot starts at the top entry
module software_managed_tlb #(
	parameter int ENTRY_COUNT = stlb_pkg::ENTRY_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] vaddr,
	input  logic        is_store,
	input  logic [1:0]  reg_sel,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] paddr,
	output logic        fault,
	output logic [31:0] read_data
);
	import stlb_pkg::*;

	cmd_t cmd;

	// sequencing
	stlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// entries, registers and lookup
	stlb_dp #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.vaddr       (vaddr),
		.is_store    (is_store),
		.reg_sel     (reg_sel),
		.write_value (write_value),
		.paddr       (paddr),
		.fault       (fault),
		.read_data   (read_data)
	);

endmodule

// File: rtl/stlb_ctrl.sv
module stlb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output stlb_pkg::cmd_t     cmd
);
	import stlb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	// the output register can take a new beat when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	// commands
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.match   = (state_q == ST_MATCH);
		cmd.exec    = (state_q == ST_EXEC) && out_free;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_MATCH;
				end
			end
			ST_MATCH: begin
				state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// a result never overwrites a beat that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(out_valid_q && out_stall))
		else $error("result written over a stalled beat");

	// an accepted request always goes to the match step
	a_capture_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_MATCH))
		else $error("accepted request did not reach match");

	// match is followed by execute
	a_match_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |=> (state_q == ST_EXEC))
		else $error("match not followed by execute");

	// executing produces a visible result beat
	a_exec_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("execute did not raise the result valid");

endmodule

// File: rtl/stlb_dp.sv
module stlb_dp #(
	parameter int ENTRY_COUNT = stlb_pkg::ENTRY_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stlb_pkg::cmd_t     cmd,
	input  logic [2:0]         req_type,
	input  logic [31:0]        vaddr,
	input  logic               is_store,
	input  logic [1:0]         reg_sel,
	input  logic [31:0]        write_value,
	output logic [31:0]        paddr,
	output logic               fault,
	output logic [31:0]        read_data
);
	import stlb_pkg::*;

	localparam int IDX_W = $clog2(ENTRY_COUNT);
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRY_COUNT - 1);
	localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(ENTRY_COUNT - 1);
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

	// captured request
	logic [2:0]   req_q;
	logic [31:0]  va_q;
	logic         store_q;
	logic [1:0]   sel_q;
	logic [31:0]  wv_q;

	// entry store and software registers
	entry_t           ent_q [ENTRY_COUNT];
	logic [31:0]      entry_hi_q;
	logic [31:0]      entry_lo_q;
	logic [IDX_W-1:0] index_q;
	logic             miss_q;
	logic [IDX_W-1:0] rand_q;
	logic [31:0]      bad_q;

	// tag compare results
	logic [ENTRY_COUNT-1:0] tag_hit_s1;
	logic [VPN_W-1:0]       key_vpn;

	// lookup results
	logic [ENTRY_COUNT-1:0] hit_vec;
	logic [ENTRY_COUNT-1:0] low_oh;
	logic                   any_hit;
	logic [IDX_W-1:0]       hit_idx;
	logic [PFN_W-1:0]       hit_pfn;
	logic                   hit_dirty;

	// entry built from entry hi / lo
	entry_t new_ent;
	entry_t rd_ent;

	// result staging
	logic [31:0] paddr_nx;
	logic        fault_nx;
	logic [31:0] rdata_nx;

	// output registers
	logic [31:0] paddr_q;
	logic        fault_q;
	logic [31:0] rdata_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			va_q    <= vaddr;
			store_q <= is_store;
			sel_q   <= reg_sel;
			wv_q    <= write_value;
		end
	end

	// probe searches entry hi, everything else the request address
	assign key_vpn = (req_q == REQ_PROBE) ? entry_hi_q[31:OFS_W] : va_q[31:OFS_W];

	// parallel tag comparators
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				tag_hit_s1[i] <= (ent_q[i].vpn == key_vpn);
			end
		end
	end

	// lowest valid hit wins
	always_comb begin
		hit_vec   = '0;
		hit_idx   = '0;
		hit_pfn   = '0;
		hit_dirty = 1'b0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			hit_vec[i] = tag_hit_s1[i] && ent_q[i].valid;
		end
		low_oh  = hit_vec & (~hit_vec + ENTRY_COUNT'(1));
		any_hit = |hit_vec;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (low_oh[i]) begin
				hit_idx   = hit_idx | IDX_W'(i);
				hit_pfn   = hit_pfn | ent_q[i].pfn;
				hit_dirty = hit_dirty | ent_q[i].dirty;
			end
		end
	end

	// entry from the software registers, and the indexed entry for read back
	always_comb begin
		new_ent.vpn   = entry_hi_q[31:OFS_W];
		new_ent.pfn   = entry_lo_q[31:OFS_W];
		new_ent.valid = entry_lo_q[1];
		new_ent.dirty = entry_lo_q[2];
		new_ent.rwx   = entry_lo_q[5:3];
		new_ent.user  = entry_lo_q[6];
		// index is always below the entry count: writes mask it, probes hit in range
		rd_ent = ent_q[index_q];
	end

	// result values
	always_comb begin
		paddr_nx = '0;
		fault_nx = 1'b0;
		rdata_nx = '0;
		case (req_q)
			REQ_TRANSLATE: begin
				if (!any_hit || (store_q && !hit_dirty)) begin
					fault_nx = 1'b1;
				end else begin
					paddr_nx = {hit_pfn, va_q[OFS_W-1:0]};
				end
			end
			REQ_REG_RD: begin
				case (sel_q)
					REG_ENTRY_HI: rdata_nx = entry_hi_q;
					REG_ENTRY_LO: rdata_nx = entry_lo_q;
					REG_INDEX:    rdata_nx = {miss_q, (31 - IDX_W)'(0), index_q};
					default:      rdata_nx = bad_q;
				endcase
			end
			default: begin
				paddr_nx = '0;
			end
		endcase
	end

	// entry store updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				ent_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				if (req_q == REQ_WRITE_RND && rand_q == IDX_W'(i)) begin
					ent_q[i] <= new_ent;
				end else if (req_q == REQ_INVAL && tag_hit_s1[i]) begin
					ent_q[i].valid <= 1'b0;
				end
			end
		end
	end

	// software registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_hi_q <= '0;
			entry_lo_q <= '0;
			index_q    <= '0;
			miss_q     <= 1'b0;
			rand_q     <= IDX_TOP;
			bad_q      <= '0;
		end else if (cmd.exec) begin
			case (req_q)
				REQ_TRANSLATE: begin
					if (!any_hit) begin
						bad_q      <= va_q;
						entry_hi_q <= va_q & PAGE_MASK;
					end else if (store_q && !hit_dirty) begin
						bad_q <= va_q;
					end
				end
				REQ_WRITE_RND: begin
					// walk downward, never landing on entry 0
					rand_q <= (rand_q <= IDX_ONE) ? IDX_TOP : rand_q - IDX_ONE;
				end
				REQ_READ_ENT: begin
					entry_hi_q <= {rd_ent.vpn, OFS_W'(0)};
					entry_lo_q <= {rd_ent.pfn, 5'd0, rd_ent.user, rd_ent.rwx,
						rd_ent.dirty, rd_ent.valid, 1'b0};
				end
				REQ_PROBE: begin
					miss_q  <= !any_hit;
					index_q <= any_hit ? hit_idx : '0;
				end
				REQ_REG_WR: begin
					case (sel_q)
						REG_ENTRY_HI: entry_hi_q <= wv_q;
						REG_ENTRY_LO: entry_lo_q <= wv_q;
						REG_INDEX: begin
							index_q <= wv_q[IDX_W-1:0] & IDX_MASK;
							miss_q  <= 1'b0;
						end
						default: begin
							// bad address is read only
							bad_q <= bad_q;
						end
					endcase
				end
				default: begin
					bad_q <= bad_q;
				end
			endcase
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			paddr_q <= paddr_nx;
			fault_q <= fault_nx;
			rdata_q <= rdata_nx;
		end
	end

	assign paddr     = paddr_q;
	assign fault     = fault_q;
	assign read_data = rdata_q;

endmodule

// File: sim/tb_software_managed_tlb.sv
module tb_software_managed_tlb;
	import stlb_pkg::*;

	localparam int ENTRIES = ENTRY_COUNT_DEF;
	localparam int TARGET_REQS = 1150;
	localparam int QUIET_TAIL = 150;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 120;
	localparam int POOL = 6;
	localparam logic [2:0] REQ_UNUSED = 3'd7;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] va;
		logic        st;
		logic [1:0]  sel;
		logic [31:0] wv;
		bit          drain;
	} tlb_req_t;

	typedef struct {
		logic [31:0] pa;
		logic        flt;
		logic [31:0] rd;
	} tlb_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [31:0] vaddr = '0;
	logic        is_store = 1'b0;
	logic [1:0]  reg_sel = '0;
	logic [31:0] write_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] paddr;
	logic        fault;
	logic [31:0] read_data;

	software_managed_tlb #(.ENTRY_COUNT(ENTRIES)) dut (.*);

	// predicted translation state
	entry_t      shadow_ent [ENTRIES];
	logic [31:0] tlb_hi;
	logic [31:0] tlb_lo;
	logic [31:0] tlb_bad_va;
	int unsigned shadow_idx;
	logic        tlb_probe_miss;
	int unsigned tlb_rnd_slot;

	tlb_req_t  pending_reqs[$];
	tlb_resp_t resp_due[$];
	tlb_req_t  cur_req;
	int        total_reqs = TARGET_REQS;
	int        reqs_taken = 0;
	int        resps_seen = 0;
	int        errors = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	int        hit_cnt = 0;
	int        miss_cnt = 0;
	int        fill_cnt = 0;

	// lowest valid entry holding the page, -1 when none
	function automatic int find_lowest_page(logic [19:0] pg);
		int hit;
		hit = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (shadow_ent[i].valid && shadow_ent[i].vpn == pg)
				hit = i;
		end
		return hit;
	endfunction

	// apply one request to the predicted state and return its result beat
	function automatic tlb_resp_t predict_tlb_response(tlb_req_t r);
		tlb_resp_t res;
		int hit;
		int unsigned slot;
		res = '{default: '0};
		case (r.kind)
			REQ_TRANSLATE: begin
				hit = find_lowest_page(r.va[31:12]);
				if (hit < 0) begin
					res.flt = 1'b1;
					tlb_bad_va = r.va;
					tlb_hi = r.va & PAGE_MASK;
					miss_cnt++;
				end else if (r.st && !shadow_ent[hit].dirty) begin
					res.flt = 1'b1;
					tlb_bad_va = r.va;
				end else begin
					res.pa = {shadow_ent[hit].pfn, r.va[11:0]};
					hit_cnt++;
				end
			end
			REQ_WRITE_RND: begin
				slot = tlb_rnd_slot;
				shadow_ent[slot] = '{vpn: tlb_hi[31:12], pfn: tlb_lo[31:12], valid: tlb_lo[1],
					dirty: tlb_lo[2], rwx: tlb_lo[5:3], user: tlb_lo[6]};
				tlb_rnd_slot = (slot <= 1) ? ENTRIES - 1 : slot - 1;
				fill_cnt++;
			end
			REQ_READ_ENT: begin
				if (shadow_idx < ENTRIES) begin
					tlb_hi = {shadow_ent[shadow_idx].vpn, 12'h000};
					tlb_lo = {shadow_ent[shadow_idx].pfn, 5'b0, shadow_ent[shadow_idx].user,
						shadow_ent[shadow_idx].rwx, shadow_ent[shadow_idx].dirty,
						shadow_ent[shadow_idx].valid, 1'b0};
				end else begin
					tlb_hi = '0;
					tlb_lo = '0;
				end
			end
			REQ_PROBE: begin
				hit = find_lowest_page(tlb_hi[31:12]);
				tlb_probe_miss = (hit < 0);
				shadow_idx = (hit < 0) ? 0 : hit;
			end
			REQ_INVAL: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (shadow_ent[i].vpn == r.va[31:12])
						shadow_ent[i].valid = 1'b0;
				end
			end
			REQ_REG_RD: begin
				case (r.sel)
					REG_ENTRY_HI: res.rd = tlb_hi;
					REG_ENTRY_LO: res.rd = tlb_lo;
					REG_INDEX: begin
						res.rd = shadow_idx;
						res.rd[31] = tlb_probe_miss;
					end
					default: res.rd = tlb_bad_va;
				endcase
			end
			REQ_REG_WR: begin
				case (r.sel)
					REG_ENTRY_HI: tlb_hi = r.wv;
					REG_ENTRY_LO: tlb_lo = r.wv;
					REG_INDEX: begin
						shadow_idx = r.wv & (ENTRIES - 1);
						tlb_probe_miss = 1'b0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return res;
	endfunction

	// idle in stretches, none in the last part of the run
	function automatic bit idle_on(int n);
		return ((n / 64) % 3 != 0) && (n < total_reqs - QUIET_TAIL);
	endfunction

	task automatic queue_req(input logic [2:0] k, input logic [31:0] va, input logic st,
			input logic [1:0] sel, input logic [31:0] wv);
		tlb_req_t r;
		r = '{kind: k, va: va, st: st, sel: sel, wv: wv, drain: 1'b0};
		pending_reqs.push_back(r);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				resp_due.push_back(predict_tlb_response(cur_req));
				reqs_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].drain && resp_due.size() != 0)) begin
					if (idle_on(reqs_taken) && $urandom_range(0, 4) == 0) begin
						gap_left = $urandom_range(0, 7);
					end else begin
						cur_req = pending_reqs.pop_front();
						offer = 1'b1;
						req_type <= cur_req.kind;
						vaddr <= cur_req.va;
						is_store <= cur_req.st;
						reg_sel <= cur_req.sel;
						write_value <= cur_req.wv;
					end
				end
			end
			in_valid <= offer;
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin : watch
		tlb_resp_t want;
		logic hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (resp_due.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = resp_due.pop_front();
					if (paddr !== want.pa) begin
						$error("paddr mismatch: expected %h, got %h", want.pa, paddr);
						errors++;
					end
					if (fault !== want.flt) begin
						$error("fault mismatch: expected %b, got %b", want.flt, fault);
						errors++;
					end
					if (read_data !== want.rd) begin
						$error("read_data mismatch: expected %h, got %h", want.rd, read_data);
						errors++;
					end
				end
				resps_seen++;
				if (resps_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				hold = 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				hold = 1'b1;
			end else if (idle_on(resps_seen) && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 7);
				hold = 1'b1;
			end else begin
				hold = 1'b0;
			end
			out_stall <= hold;
		end
	end

	initial begin : main
		logic [19:0] page_pool [POOL];
		logic [19:0] pg;
		logic [31:0] va;
		logic [31:0] lo;
		int n;

		for (int i = 0; i < ENTRIES; i++)
			shadow_ent[i] = '0;
		tlb_hi = '0;
		tlb_lo = '0;
		tlb_bad_va = '0;
		shadow_idx = 0;
		tlb_probe_miss = 1'b0;
		tlb_rnd_slot = ENTRIES - 1;

		// reset values of every register
		queue_req(REQ_REG_RD, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_ENTRY_LO, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_INDEX, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_BAD_ADDR, '0);
		// miss loads entry hi and bad address
		queue_req(REQ_TRANSLATE, 32'hFFFF_FFFF, 1'b1, REG_ENTRY_HI, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_BAD_ADDR, '0);
		// top page, all flag bits and ignored bits set
		queue_req(REQ_REG_WR, '0, 1'b0, REG_ENTRY_HI, 32'hFFFF_F123);
		queue_req(REQ_REG_WR, '0, 1'b0, REG_ENTRY_LO, 32'hFFFF_FFFF);
		queue_req(REQ_WRITE_RND, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_TRANSLATE, 32'hFFFF_FABC, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_TRANSLATE, 32'hFFFF_F000, 1'b1, REG_ENTRY_HI, '0);
		// page zero, valid but clean
		queue_req(REQ_REG_WR, '0, 1'b0, REG_ENTRY_HI, 32'h0000_0000);
		queue_req(REQ_REG_WR, '0, 1'b0, REG_ENTRY_LO, 32'h0000_1002);
		queue_req(REQ_WRITE_RND, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_TRANSLATE, 32'h0000_0FFF, 1'b1, REG_ENTRY_HI, '0);
		// probe hit, then read back the entry
		queue_req(REQ_PROBE, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_READ_ENT, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_ENTRY_LO, '0);
		// probe miss, then a read falls back to entry 0
		queue_req(REQ_REG_WR, '0, 1'b0, REG_ENTRY_HI, 32'h1234_5000);
		queue_req(REQ_PROBE, '0, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_INDEX, '0);
		queue_req(REQ_READ_ENT, '0, 1'b0, REG_ENTRY_HI, '0);
		// invalidate, read-only register write, unused code
		queue_req(REQ_INVAL, 32'h0000_0ABC, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_TRANSLATE, 32'h0000_0010, 1'b0, REG_ENTRY_HI, '0);
		queue_req(REQ_REG_WR, '0, 1'b0, REG_BAD_ADDR, 32'hFFFF_FFFF);
		queue_req(REQ_REG_RD, '0, 1'b0, REG_BAD_ADDR, '0);
		queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, REG_BAD_ADDR, 32'hFFFF_FFFF);

		// random sequences over a small page pool so lookups mostly hit
		for (int i = 0; i < POOL; i++)
			page_pool[i] = 20'($urandom);
		while (pending_reqs.size() < TARGET_REQS) begin
			if ($urandom_range(0, 15) == 0)
				page_pool[$urandom_range(0, POOL - 1)] = 20'($urandom);
			pg = page_pool[$urandom_range(0, POOL - 1)];
			va = {pg, 12'($urandom)};
			case ($urandom_range(0, 9))
				0, 1: begin
					// fill through entry hi / entry lo
					lo = $urandom;
					if ($urandom_range(0, 7) != 0)
						lo[1] = 1'b1;
					queue_req(REQ_REG_WR, $urandom, 1'($urandom), REG_ENTRY_HI, va);
					queue_req(REQ_REG_WR, $urandom, 1'($urandom), REG_ENTRY_LO, lo);
					queue_req(REQ_WRITE_RND, $urandom, 1'($urandom), 2'($urandom), $urandom);
				end
				2, 3, 4: begin
					n = $urandom_range(1, 3);
					repeat (n) begin
						va = {page_pool[$urandom_range(0, POOL - 1)], 12'($urandom)};
						if ($urandom_range(0, 5) == 0)
							va = $urandom;
						queue_req(REQ_TRANSLATE, va, 1'($urandom), 2'($urandom), $urandom);
					end
				end
				5: begin
					if ($urandom_range(0, 3) == 0)
						va = $urandom;
					queue_req(REQ_REG_WR, $urandom, 1'($urandom), REG_ENTRY_HI, va);
					queue_req(REQ_PROBE, $urandom, 1'($urandom), 2'($urandom), $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), REG_INDEX, $urandom);
					queue_req(REQ_READ_ENT, $urandom, 1'($urandom), 2'($urandom), $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), REG_ENTRY_HI, $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), REG_ENTRY_LO, $urandom);
				end
				6: begin
					queue_req(REQ_INVAL, va, 1'($urandom), 2'($urandom), $urandom);
					queue_req(REQ_TRANSLATE, va, 1'($urandom), 2'($urandom), $urandom);
				end
				7: begin
					queue_req(REQ_REG_WR, $urandom, 1'($urandom), REG_INDEX, $urandom);
					queue_req(REQ_READ_ENT, $urandom, 1'($urandom), 2'($urandom), $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), REG_ENTRY_HI, $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), REG_ENTRY_LO, $urandom);
				end
				8: begin
					lo = $urandom;
					queue_req(REQ_REG_WR, $urandom, 1'($urandom), lo[1:0], $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), lo[1:0], $urandom);
					queue_req(REQ_REG_RD, $urandom, 1'($urandom), 2'($urandom), $urandom);
				end
				default: begin
					queue_req(3'($urandom), $urandom, 1'($urandom), 2'($urandom), $urandom);
				end
			endcase
		end
		total_reqs = pending_reqs.size();
		pending_reqs[total_reqs / 2].drain = 1'b1;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (reqs_taken != total_reqs || resp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests: %0d translate hits, %0d misses, %0d entry fills",
			reqs_taken, hit_cnt, miss_cnt, fill_cnt);
		$display("with output hold-off, drain pause and random idling on both sides");
		if (errors == 0)
			$display("[software_managed_tlb] OK");
		else
			$display("[software_managed_tlb] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$error("timeout with %0d results still due", resp_due.size());
		$display("[software_managed_tlb] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/stlb_pkg.sv
rtl/stlb_ctrl.sv
rtl/stlb_dp.sv
rtl/software_managed_tlb.sv
sim/tb_software_managed_tlb.sv
